@@ src/gda_pkg.sv @@
// Shared types and constants for the Gregorian date-plus-days unit.
// No dependencies.
`default_nettype none

package gda_pkg;

    localparam int ADD_BITS_DEF = 15;
    localparam int YEAR_IN_W    = 14;
    localparam int YEAR_W       = 15;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int STEP_W       = 3;

    localparam logic [YEAR_IN_W-1:0] CYCLE_400  = YEAR_IN_W'(400);
    localparam logic [YEAR_IN_W-1:0] CYCLE_LAST = YEAR_IN_W'(399);
    localparam logic [YEAR_IN_W-1:0] CENT_1     = YEAR_IN_W'(100);
    localparam logic [YEAR_IN_W-1:0] CENT_2     = YEAR_IN_W'(200);
    localparam logic [YEAR_IN_W-1:0] CENT_3     = YEAR_IN_W'(300);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // datapath test selected by the current control word
    typedef enum logic [2:0] {
        C_IN_VALID,
        C_GE400,
        C_BAD,
        C_MONTH_LT,
        C_FITS,
        C_OUT_FREE
    } cond_t;

    // datapath operation
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SUB400,
        OP_ECHO,
        OP_INIT,
        OP_ACC,
        OP_ADD_DAYS,
        OP_STEP,
        OP_PUT
    } op_t;

    typedef struct packed {
        cond_t             cond;
        op_t               op_hit;
        logic [STEP_W-1:0] next_hit;
        op_t               op_miss;
        logic [STEP_W-1:0] next_miss;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic ge400;
        logic bad;
        logic month_lt;
        logic fits;
        logic out_free;
    } gda_flags_t;

    localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_REDUCE = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_CHECK  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_ORD    = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_WALK   = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_PUT    = STEP_W'(5);

    // days in month m; 0 for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] m,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
                4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
                4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
                default: len = '0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/gda_if.sv @@
// Valid/ready channels for the date unit: query (start date, day count)
// and answer (result date, error flag). Depends on gda_pkg.
`default_nettype none

interface gda_query_if
    import gda_pkg::*;
#(
    parameter int ADD_BITS = ADD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [YEAR_IN_W-1:0] start_year;
    logic [MONTH_W-1:0]   start_month;
    logic [DAY_W-1:0]     start_day;
    logic [ADD_BITS-1:0]  days_to_add;

    modport source (output valid, start_year, start_month, start_day, days_to_add,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                    output ready);
endinterface

interface gda_answer_if
    import gda_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [YEAR_IN_W-1:0] result_year;
    logic [MONTH_W-1:0]   result_month;
    logic [DAY_W-1:0]     result_day;
    logic                 bad_date;

    modport source (output valid, result_year, result_month, result_day, bad_date,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, bad_date,
                    output ready);
endinterface

`default_nettype wire

@@ src/gda_seq.sv @@
// Microcode sequencer: control ROM and step counter with two-way jumps.
// Depends on gda_pkg.
`default_nettype none

module gda_seq
    import gda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gda_flags_t        flags,
    output logic [STEP_W-1:0]      step,
    output op_t                    op
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            uword;
    logic              hit;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] s);
        ucode_t w;
        begin
            unique case (s)
                STEP_IDLE:
                    w = '{C_IN_VALID, OP_LOAD, STEP_REDUCE, OP_NOP, STEP_IDLE};
                STEP_REDUCE:
                    w = '{C_GE400, OP_SUB400, STEP_REDUCE, OP_NOP, STEP_CHECK};
                STEP_CHECK:
                    w = '{C_BAD, OP_ECHO, STEP_PUT, OP_INIT, STEP_ORD};
                STEP_ORD:
                    w = '{C_MONTH_LT, OP_ACC, STEP_ORD, OP_ADD_DAYS, STEP_WALK};
                STEP_WALK:
                    w = '{C_FITS, OP_NOP, STEP_PUT, OP_STEP, STEP_WALK};
                STEP_PUT:
                    w = '{C_OUT_FREE, OP_PUT, STEP_IDLE, OP_NOP, STEP_PUT};
                default:
                    w = '{C_IN_VALID, OP_NOP, STEP_IDLE, OP_NOP, STEP_IDLE};
            endcase
            return w;
        end
    endfunction

    always_comb
    begin
        uword = ucode_rom(step_reg);
        unique case (uword.cond)
            C_IN_VALID: hit = flags.in_valid;
            C_GE400:    hit = flags.ge400;
            C_BAD:      hit = flags.bad;
            C_MONTH_LT: hit = flags.month_lt;
            C_FITS:     hit = flags.fits;
            C_OUT_FREE: hit = flags.out_free;
            default:    hit = 1'b0;
        endcase
        step_next = hit ? uword.next_hit : uword.next_miss;
        op        = hit ? uword.op_hit : uword.op_miss;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

    assign step = step_reg;

endmodule

`default_nettype wire

@@ src/gregorian_date_add_days_unit.sv @@
// Gregorian date plus a day count: microcoded datapath and output register.
// Depends on gda_pkg, gda_if (gda_query_if, gda_answer_if) and gda_seq.
//
// Usage:
//   query  (sink): start_year, start_month, start_day, days_to_add. An item
//          is taken when valid and ready are high at a clock edge; ready is
//          high only while the sequencer sits in its idle step.
//   answer (source): result_year, result_month, result_day, bad_date, held
//          in an output register until the receiver takes it.
//   Per item the sequencer steps through a load, the year/400 reduction
//   loop and its exit step, a date check, the ordinal loop over the months
//   before the start month, and a month-by-month walk that subtracts month
//   lengths until the rest fits, then the output step; the month-subtract
//   walk dominates. A new item is taken only once the last has been put.
//   An invalid start date skips the ordinal loop and the walk.
//   The next item is taken while a finished result still waits in the
//   output register; a stalled receiver holds the sequencer only at its
//   output step. Reset returns the sequencer to idle and empties the output.
`default_nettype none

module gregorian_date_add_days_unit
    import gda_pkg::*;
#(
    parameter int ADD_BITS = ADD_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    gda_query_if.sink    query,
    gda_answer_if.source answer
);

    localparam int REM_W = ((ADD_BITS > 9) ? ADD_BITS : 9) + 1;

    logic [YEAR_W-1:0]    year_reg,  year_next;
    logic [YEAR_IN_W-1:0] r400_reg,  r400_next;
    logic [MONTH_W-1:0]   smon_reg,  smon_next;
    logic [DAY_W-1:0]     sday_reg,  sday_next;
    logic [ADD_BITS-1:0]  add_reg,   add_next;
    logic [MONTH_W-1:0]   m_reg,     m_next;
    logic [REM_W-1:0]     rem_reg,   rem_next;
    logic                 bad_reg,   bad_next;

    logic                 ovalid_reg, ovalid_next;
    logic [YEAR_IN_W-1:0] oyear_reg,  oyear_next;
    logic [MONTH_W-1:0]   omon_reg,   omon_next;
    logic [DAY_W-1:0]     oday_reg,   oday_next;
    logic                 obad_reg,   obad_next;

    logic [STEP_W-1:0]    step;
    op_t                  op;
    gda_flags_t           flags;
    logic                 leap;
    logic [DAY_W-1:0]     len_m;
    logic [DAY_W-1:0]     len_start;

    gda_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .step  (step),
        .op    (op)
    );

    assign leap = (year_reg[1:0] == 2'd0) && (r400_reg != CENT_1)
                  && (r400_reg != CENT_2) && (r400_reg != CENT_3);
    assign len_m     = month_length(m_reg, leap);
    assign len_start = month_length(smon_reg, leap);

    always_comb
    begin
        flags.in_valid = query.valid;
        flags.ge400    = (r400_reg >= CYCLE_400);
        flags.bad      = (len_start == '0) || (sday_reg == '0) || (sday_reg > len_start);
        flags.month_lt = (m_reg < smon_reg);
        flags.fits     = (rem_reg <= REM_W'(len_m));
        flags.out_free = !ovalid_reg || answer.ready;
    end

    always_comb
    begin
        year_next   = year_reg;
        r400_next   = r400_reg;
        smon_next   = smon_reg;
        sday_next   = sday_reg;
        add_next    = add_reg;
        m_next      = m_reg;
        rem_next    = rem_reg;
        bad_next    = bad_reg;
        oyear_next  = oyear_reg;
        omon_next   = omon_reg;
        oday_next   = oday_reg;
        obad_next   = obad_reg;
        ovalid_next = ovalid_reg && !answer.ready;

        unique case (op)
            OP_LOAD:
            begin
                year_next = YEAR_W'(query.start_year);
                r400_next = query.start_year;
                smon_next = query.start_month;
                sday_next = query.start_day;
                add_next  = query.days_to_add;
            end
            OP_SUB400:
                r400_next = r400_reg - CYCLE_400;
            OP_ECHO:
            begin
                bad_next = 1'b1;
                m_next   = smon_reg;
                rem_next = REM_W'(sday_reg);
            end
            OP_INIT:
            begin
                bad_next = 1'b0;
                m_next   = MONTH_JAN;
                rem_next = REM_W'(sday_reg);
            end
            OP_ACC:
            begin
                rem_next = rem_reg + REM_W'(len_m);
                m_next   = m_reg + MONTH_JAN;
            end
            OP_ADD_DAYS:
            begin
                rem_next = rem_reg + REM_W'(add_reg);
                m_next   = MONTH_JAN;
            end
            OP_STEP:
            begin
                rem_next = rem_reg - REM_W'(len_m);
                if (m_reg == MONTH_DEC)
                begin
                    m_next    = MONTH_JAN;
                    year_next = year_reg + YEAR_W'(1);
                    r400_next = (r400_reg == CYCLE_LAST) ? '0 : r400_reg + YEAR_IN_W'(1);
                end
                else
                begin
                    m_next = m_reg + MONTH_JAN;
                end
            end
            OP_PUT:
            begin
                ovalid_next = 1'b1;
                oyear_next  = year_reg[YEAR_IN_W-1:0];
                omon_next   = m_reg;
                oday_next   = rem_reg[DAY_W-1:0];
                obad_next   = bad_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        r400_reg  <= r400_next;
        smon_reg  <= smon_next;
        sday_reg  <= sday_next;
        add_reg   <= add_next;
        m_reg     <= m_next;
        rem_reg   <= rem_next;
        bad_reg   <= bad_next;
        oyear_reg <= oyear_next;
        omon_reg  <= omon_next;
        oday_reg  <= oday_next;
        obad_reg  <= obad_next;
    end

    assign query.ready         = (step == STEP_IDLE);
    assign answer.valid        = ovalid_reg;
    assign answer.result_year  = oyear_reg;
    assign answer.result_month = omon_reg;
    assign answer.result_day   = oday_reg;
    assign answer.bad_date     = obad_reg;

endmodule

`default_nettype wire
